// File: sv/zipf_pkg.sv
`default_nettype none

package zipf_pkg;

    // Field widths of the stream items
    localparam int OP_W   = 2;
    localparam int IDX_W  = 10;
    localparam int DRAW_W = 31;
    localparam int RANK_W = 11;

    // Packed bus widths: input tdata = entry_index, cdf_value, seed_value (72 bits)
    // output tdata = sample_rank, uniform_draw, padded to 48 bits
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 48;
    localparam int M_PAD_W  = M_DATA_W - RANK_W - DRAW_W;

    // Minimal-standard generator: x' = A * x mod M, M = 2^31 - 1
    localparam int              MULT_W = 15;
    localparam logic [MULT_W-1:0] LCG_A  = 15'd16807;
    localparam logic [DRAW_W-1:0] LCG_M  = 31'h7FFF_FFFF;
    localparam int              PROD_W = DRAW_W + MULT_W;

    localparam logic [RANK_W-1:0] ITEM_COUNT_RST = 11'd1024;
    localparam logic [DRAW_W-1:0] GEN_STATE_RST  = 31'd1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_SEED  = 2'd1,
        OP_DRAW  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FOLD,
        ST_SEARCH,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic write_entry;
        logic load_seed;
        logic mul;
        logic fold;
        logic step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic last_step;
    } t_dp_status;

endpackage

`default_nettype wire

// File: sv/zipf_ctrl.sv
`default_nettype none

module zipf_ctrl
    import zipf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_valid,
    input  wire logic [OP_W-1:0]  i_op,
    output logic                  o_s_ready,
    output logic                  o_m_valid,
    input  wire logic             i_m_ready,
    input  wire t_dp_status       i_status,
    output t_dp_cmd               o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_m_ready;
        o_cmd       = '0;
        o_s_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    unique case (t_op'(i_op))
                        OP_WRITE: o_cmd.write_entry = 1'b1;
                        OP_SEED:  o_cmd.load_seed   = 1'b1;
                        OP_DRAW:  n_state           = ST_MUL;
                        default:  ; // drop unknown op
                    endcase
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FOLD;
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = ST_SEARCH;
            end
            ST_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_status.last_step) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_m_valid = r_out_valid;

    a_push_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) && r_out_valid && !i_m_ready |=> (r_state == ST_PUSH))
        else $error("result left push state while output register was full");

    a_draw_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_valid && o_s_ready && (i_op == OP_DRAW) |=> (r_state == ST_MUL))
        else $error("accepted draw did not start the generator step");

endmodule

`default_nettype wire

// File: sv/zipf_datapath.sv
`default_nettype none

module zipf_datapath
    import zipf_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
)
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [IDX_W-1:0]  i_entry_index,
    input  wire logic [DRAW_W-1:0] i_cdf_value,
    input  wire logic [DRAW_W-1:0] i_seed_value,
    input  wire logic [RANK_W-1:0] i_n,
    output t_dp_status             o_status,
    output logic [RANK_W-1:0]      o_sample_rank,
    output logic [DRAW_W-1:0]      o_uniform_draw,
    output logic                   o_not_found
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    logic [DRAW_W-1:0] mem [MAX_ITEMS];
    logic [DRAW_W-1:0] r_rd_data;
    logic [DRAW_W-1:0] r_state;
    logic [PROD_W-1:0] r_prod;
    logic [RANK_W-1:0] r_idx;
    logic              r_hit;
    logic [RANK_W-1:0] r_rank;
    logic [DRAW_W-1:0] r_draw;
    logic              r_nf;

    logic [DRAW_W:0]   fold_sum;
    logic [DRAW_W-1:0] fold_val;
    logic              seed_ok;
    logic              hit;
    logic [RANK_W-1:0] idx_inc;
    logic              scan_done;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;

    // Mersenne fold: high part of A*x wraps around with weight one
    always_comb begin
        fold_sum = {1'b0, r_prod[DRAW_W-1:0]} + (DRAW_W+1)'(r_prod[PROD_W-1:DRAW_W]);
        if (fold_sum >= {1'b0, LCG_M}) begin
            fold_val = DRAW_W'(fold_sum - {1'b0, LCG_M});
        end else begin
            fold_val = DRAW_W'(fold_sum);
        end
    end

    assign seed_ok = (i_seed_value != '0) && (i_seed_value != LCG_M);

    // One scan step: the entry read for r_idx against the draw; stop on the
    // first entry that reaches it or on the last rank in use
    always_comb begin
        hit       = (r_rd_data >= r_state);
        idx_inc   = RANK_W'(r_idx + 1'b1);
        scan_done = hit || (idx_inc == i_n);
    end

    assign o_status.last_step = scan_done;

    assign rd_en   = i_cmd.fold | (i_cmd.step & ~scan_done);
    assign rd_addr = i_cmd.fold ? '0 : AW'(idx_inc);
    assign wr_en   = i_cmd.write_entry && (32'(i_entry_index) < MAX_ITEMS);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(i_entry_index)] <= i_cdf_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GEN_STATE_RST;
        end else if (i_cmd.load_seed && seed_ok) begin
            r_state <= i_seed_value;
        end else if (i_cmd.fold) begin
            r_state <= fold_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_state) * PROD_W'(LCG_A);
        end
        if (i_cmd.fold) begin
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_hit <= hit;
            if (!scan_done) begin
                r_idx <= idx_inc;
            end
        end
        if (i_cmd.load_out) begin
            r_nf   <= ~r_hit;
            r_rank <= idx_inc;
            r_draw <= r_state;
        end
    end

    assign o_sample_rank  = r_rank;
    assign o_uniform_draw = r_draw;
    assign o_not_found    = r_nf;

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != '0) && (r_state != LCG_M))
        else $error("generator state left the range 1 to 2^31-2");

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_idx < i_n))
        else $error("scan index beyond the rank count");

endmodule

`default_nettype wire

// File: sv/zipf_sampler_with_lcg.sv
// Write and seed items are taken in the idle state and can follow back to back.
// A draw holds the input through the multiply, fold, search and push states, with one
// table read per cycle from rank 1 upward in search; a full output register adds its stall.
// o_m_axis_tvalid is registered and rises when the push state hands over the result.
// Reset (i_rst_n low, synchronous) sets the generator to 1, the rank count to 1024
// and empties the output register; the probability table is not cleared.
`default_nettype none

module zipf_sampler_with_lcg
    import zipf_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
)
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    // Rank count register
    input  wire logic                i_cfg_wr_en,
    input  wire logic [RANK_W-1:0]   i_cfg_wr_data,    // item_count

    // Command stream
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  wire logic [S_DATA_W-1:0] i_s_axis_tdata,   // entry_index[9:0], cdf_value[40:10],
                                                       // seed_value[71:41]
    input  wire logic [OP_W-1:0]     i_s_axis_tuser,   // op[1:0]

    // Sample stream
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0]      o_m_axis_tdata,   // sample_rank[10:0], uniform_draw[41:11],
                                                       // zero pad[47:42]
    output logic [0:0]               o_m_axis_tuser    // not_found[0]
);

    logic [RANK_W-1:0] r_item_count;
    logic [RANK_W-1:0] n_items;

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic [RANK_W-1:0] sample_rank;
    logic [DRAW_W-1:0] uniform_draw;
    logic              not_found;

    // The user must change the rank count only while the block is idle; the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= ITEM_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            r_item_count <= i_cfg_wr_data;
        end
    end

    // Clamp the rank count into 1..MAX_ITEMS
    always_comb begin
        priority if (r_item_count == '0) begin
            n_items = RANK_W'(1);
        end else if (32'(r_item_count) > MAX_ITEMS) begin
            n_items = RANK_W'(MAX_ITEMS);
        end else begin
            n_items = r_item_count;
        end
    end

    // Sequencer: idle -> generator multiply -> fold -> search steps -> push
    zipf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_op      (i_s_axis_tuser),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    // Generator, table memory, linear scan and output payload
    zipf_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_entry_index  (i_s_axis_tdata[IDX_W-1:0]),
        .i_cdf_value    (i_s_axis_tdata[IDX_W+DRAW_W-1:IDX_W]),
        .i_seed_value   (i_s_axis_tdata[IDX_W+2*DRAW_W-1:IDX_W+DRAW_W]),
        .i_n            (n_items),
        .o_status       (status),
        .o_sample_rank  (sample_rank),
        .o_uniform_draw (uniform_draw),
        .o_not_found    (not_found)
    );

    assign o_m_axis_tdata = {{M_PAD_W{1'b0}}, uniform_draw, sample_rank};
    assign o_m_axis_tuser = not_found;

endmodule

`default_nettype wire

// File: bench/tb_zipf_sampler_with_lcg.sv
`timescale 1ns / 100ps

module tb_zipf_sampler_with_lcg;
    import zipf_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int SETTLE_CYCLES = 20;      // quiet cycles before the rank count changes
    localparam int STALL_LIMIT = 8000;      // cycles with no item moving on either side

    // op code the block leaves unused; it must be dropped without effect
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [DRAW_W-1:0] cdf;
        logic [DRAW_W-1:0] seed;
    } t_cmd;

    typedef struct {
        logic [RANK_W-1:0] rank;
        logic [DRAW_W-1:0] draw;
        logic              miss;
    } t_sample;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [RANK_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]     s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;

    zipf_sampler_with_lcg dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),      // entry_index[9:0], cdf_value[40:10], seed_value[71:41]
        .i_s_axis_tuser  (s_tuser),      // op[1:0]
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),      // sample_rank[10:0], uniform_draw[41:11], pad[47:42]
        .o_m_axis_tuser  (m_tuser)       // not_found[0]
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_cmd              pending_cmds[$];     // items waiting for the driver
    t_sample           due_samples[$];      // predicted samples, oldest first
    t_cmd              cur_cmd;             // item now on the slave bus
    t_sample           want;
    int unsigned       errors = 0;
    int unsigned       quiet_cycles = 0;
    bit                calm = 1'b0;         // suppress idling on both sides

    // predictor copy of the block
    logic [DRAW_W-1:0] model_cdf[TABLE_DEPTH];
    logic [DRAW_W-1:0] model_gen = GEN_STATE_RST;
    logic [RANK_W-1:0] model_count = ITEM_COUNT_RST;

    // table as the stimulus generator has planned it (runs ahead of the block)
    logic [DRAW_W-1:0] plan_cdf[TABLE_DEPTH];

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 20);
    endfunction

    function automatic int unsigned ranks_in_use(input logic [RANK_W-1:0] count);
        if (count == 0)
            return 1;
        if (count > TABLE_DEPTH)
            return TABLE_DEPTH;
        return count;
    endfunction

    // one minimal-standard step, x * 16807 mod (2^31 - 1), done in wide arithmetic
    function automatic logic [DRAW_W-1:0] park_miller(input logic [DRAW_W-1:0] x);
        logic [63:0] prod;
        prod = 64'(LCG_A) * 64'(x);
        return DRAW_W'(prod % 64'(LCG_M));
    endfunction

    // Apply one accepted item to the predictor; queue the sample a draw yields.
    task automatic sampler_step(input t_cmd c);
        t_sample     s;
        int unsigned n;
        int unsigned i;
        case (c.op)
            OP_WRITE: begin
                model_cdf[c.idx] = c.cdf;
            end
            OP_SEED: begin
                // zero and the modulus itself would lock the generator: keep old state
                if (c.seed != '0 && c.seed != LCG_M)
                    model_gen = c.seed;
            end
            OP_DRAW: begin
                n = ranks_in_use(model_count);
                model_gen = park_miller(model_gen);
                // lowest rank whose entry reaches the draw; rank n flagged if none
                s.rank = RANK_W'(n);
                s.miss = 1'b1;
                s.draw = model_gen;
                for (i = 0; i < n; i++) begin
                    if (model_cdf[i] >= model_gen) begin
                        s.rank = RANK_W'(i + 1);
                        s.miss = 1'b0;
                        break;
                    end
                end
                due_samples.push_back(s);
            end
            default: begin
                // unused op: no state change, no sample
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued items, hold each until taken, idle at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                sampler_step(cur_cmd);
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() != 0 && !take_break()) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_cmd.seed, cur_cmd.cdf, cur_cmd.idx};
                    s_tuser  <= cur_cmd.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the sample stream at random, check each sample taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_tready <= !take_break();
        if (i_rst_n && m_tvalid && m_tready) begin
            if (due_samples.size() == 0) begin
                errors++;
                $error("unexpected sample: rank %0d draw %0d not_found %0b",
                       m_tdata[RANK_W-1:0], m_tdata[RANK_W+DRAW_W-1:RANK_W], m_tuser[0]);
            end else begin
                want = due_samples.pop_front();
                if (m_tdata[RANK_W-1:0] !== want.rank) begin
                    errors++;
                    $error("sample_rank: expected %0d, got %0d", want.rank, m_tdata[RANK_W-1:0]);
                end
                if (m_tdata[RANK_W+DRAW_W-1:RANK_W] !== want.draw) begin
                    errors++;
                    $error("uniform_draw: expected %0d, got %0d",
                           want.draw, m_tdata[RANK_W+DRAW_W-1:RANK_W]);
                end
                if (m_tuser[0] !== want.miss) begin
                    errors++;
                    $error("not_found: expected %0b, got %0b", want.miss, m_tuser[0]);
                end
            end
        end
    end

    // Watchdog: give up when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [DRAW_W-1:0] rand_word();
        return DRAW_W'($urandom);
    endfunction

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [DRAW_W-1:0] cdf, input logic [DRAW_W-1:0] seed);
        t_cmd c;
        c.op   = op;
        c.idx  = idx;
        c.cdf  = cdf;
        c.seed = seed;
        if (op == OP_WRITE)
            plan_cdf[idx] = cdf;
        pending_cmds.push_back(c);
    endtask

    // Wait until every item is taken and every sample checked, then let
    // write and seed items still in the block settle.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_cmds.size() != 0 || s_tvalid || due_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called with the block idle; the predictor follows at once.
    task automatic set_item_count(input logic [RANK_W-1:0] count);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        model_count = count;
    endtask

    // Mostly draws on a table that stays sorted, with some out-of-order entries,
    // reseeds (a few of them invalid) and unused ops mixed in.
    task automatic random_phase(input int unsigned n_items);
        int unsigned       n;
        int unsigned       k;
        int unsigned       r;
        logic [IDX_W-1:0]  idx;
        logic [DRAW_W-1:0] v;
        longint unsigned   lo;
        longint unsigned   hi;
        n = ranks_in_use(model_count);
        for (k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r < 55) begin
                queue_cmd(OP_DRAW, IDX_W'($urandom), rand_word(), rand_word());
            end else if (r < 80) begin
                // favor ranks that take part in the search
                idx = ($urandom_range(9) < 7) ? IDX_W'($urandom_range(n - 1))
                                              : IDX_W'($urandom);
                lo = (idx > 0) ? plan_cdf[idx - 1] : 0;
                hi = (idx < TABLE_DEPTH - 1) ? plan_cdf[idx + 1] : LCG_M;
                if ($urandom_range(9) == 0 || lo > hi)
                    v = rand_word();
                else
                    v = DRAW_W'(lo + (longint'($urandom) % (hi - lo + 1)));
                queue_cmd(OP_WRITE, idx, v, rand_word());
            end else if (r < 93) begin
                if ($urandom_range(19) == 0)
                    v = $urandom_range(1) ? LCG_M : '0;
                else
                    v = DRAW_W'($urandom_range(32'h7FFF_FFFE, 1));
                queue_cmd(OP_SEED, IDX_W'($urandom), rand_word(), v);
            end else begin
                queue_cmd(OP_NONE, IDX_W'($urandom), rand_word(), rand_word());
            end
        end
    endtask

    logic [RANK_W-1:0] phase_counts[10] = '{11'd1, 11'd2047, 11'd5, 11'd1024, 11'd0,
                                            11'd2, 11'd1023, 11'd0, 11'd16, 11'd700};
    logic [DRAW_W-1:0] sorted_cdf[$];
    int unsigned       p;

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, one rank in use (count 0 acts as 1); only entry 0 is read.
        set_item_count('0);
        queue_cmd(OP_WRITE, '0, LCG_M, '0);              // entry 0 at full scale
        queue_cmd(OP_DRAW, '0, '0, '0);                  // first step from reset state
        queue_cmd(OP_SEED, '1, '1, '0);                  // invalid seed: zero
        queue_cmd(OP_SEED, '0, '0, LCG_M);               // invalid seed: modulus
        queue_cmd(OP_NONE, '1, '1, '1);                  // unused op
        queue_cmd(OP_DRAW, '1, '1, '1);
        queue_cmd(OP_WRITE, '0, '0, '1);                 // empty distribution
        queue_cmd(OP_DRAW, '0, '0, '0);                  // nothing qualifies
        queue_cmd(OP_SEED, '0, '0, LCG_M - 1);           // largest valid seed
        queue_cmd(OP_DRAW, '0, '0, '0);
        queue_cmd(OP_SEED, '0, '0, DRAW_W'(1));
        queue_cmd(OP_WRITE, '0, DRAW_W'(16807), '0);     // entry equal to the next draw
        queue_cmd(OP_DRAW, '0, '0, '0);
        queue_cmd(OP_WRITE, '1, '0, '0);                 // top entry, refilled below
        queue_cmd(OP_DRAW, '0, '0, '0);                  // draw now above entry 0
        wait_drained();

        // Load the whole table with sorted random levels so any count is safe to draw.
        repeat (TABLE_DEPTH) sorted_cdf.push_back(rand_word());
        sorted_cdf.sort();
        for (p = 0; p < TABLE_DEPTH; p++)
            queue_cmd(OP_WRITE, IDX_W'(p), sorted_cdf[p], rand_word());
        wait_drained();

        // Random phases over a range of rank counts; one of them runs without idling.
        for (p = 0; p < 10; p++) begin
            set_item_count(p == 7 ? RANK_W'($urandom_range(2047)) : phase_counts[p]);
            calm = (p == 3);
            random_phase(80);
            wait_drained();
        end
        calm = 1'b0;

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/zipf_pkg.sv
sv/zipf_ctrl.sv
sv/zipf_datapath.sv
sv/zipf_sampler_with_lcg.sv
bench/tb_zipf_sampler_with_lcg.sv
